// File: design/hbfc_pkg.sv
package hbfc_pkg;

  typedef enum logic [1:0] {
    ACT_H2F = 2'd0,
    ACT_F2H = 2'd1,
    ACT_B2F = 2'd2,
    ACT_F2B = 2'd3
  } act_t;

  localparam logic [7:0]  F32_EXP_MAX  = 8'hFF;
  localparam logic [7:0]  H_BIAS_DIFF  = 8'd112;
  localparam logic [7:0]  F2H_UF_EXP   = 8'd102;
  localparam logic [7:0]  F2H_SUB_TOP  = 8'd113;
  localparam logic [7:0]  F2H_OF_EXP   = 8'd143;
  localparam logic [4:0]  H_EXP_MAX    = 5'h1F;
  localparam logic [9:0]  H_QNAN_BIT   = 10'h200;
  localparam logic [6:0]  BF_QNAN_BIT  = 7'h40;
  localparam logic [31:0] BF_RND_BIAS  = 32'h0000_7FFF;

  // leading zeros of a 10-bit half mantissa
  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] n;
    logic       found;
    n     = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) begin
          found = 1'b1;
        end else begin
          n = n + 4'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

// File: design/half_bf16_float_converter_unit.sv
// Channel | Ports                         | Word
// --------+-------------------------------+-----------------------------------
// input   | in_valid, in_ready            | in_action[1:0], in_value[31:0]
// result  | out_valid, out_ready          | out_result[31:0]
//
// One word per cycle sustained while out_ready is high; out_valid follows the result register.
// Input register -> conversion logic -> result register, each stage advancing
// when the stage after it is empty or draining.
// Synchronous active-low reset clears both stage valid flags only.
// A stall on out_ready backs up through both registers, then drops in_ready.
module half_bf16_float_converter_unit
  import hbfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result
);

  logic        s1_valid_r;
  act_t        s1_act_r;
  logic [31:0] s1_value_r;
  logic        out_valid_r;
  logic [31:0] out_result_r;

  logic        s2_ready;
  logic        s1_ready;
  logic [31:0] res_nxt;

  assign s2_ready   = !out_valid_r || out_ready;
  assign s1_ready   = !s1_valid_r || s2_ready;
  assign in_ready   = s1_ready;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // half to float
  logic        h_s;
  logic [4:0]  h_e;
  logic [9:0]  h_m;
  logic [3:0]  h_lz;
  logic [9:0]  h_sub_m;
  logic [7:0]  h_sub_e;
  logic [31:0] h2f;

  // float to half
  logic        f_s;
  logic [7:0]  f_e;
  logic [22:0] f_m;
  logic [3:0]  f_sh;
  logic [23:0] f_sub_sh;
  logic [10:0] f_sub;
  logic [4:0]  f_ex;
  logic [14:0] f_norm;
  logic [15:0] f2h;

  // bfloat16
  logic [31:0] b_sum;
  logic [15:0] f2b;

  always_comb begin
    h_s     = s1_value_r[15];
    h_e     = s1_value_r[14:10];
    h_m     = s1_value_r[9:0];
    h_lz    = lzc10(h_m);
    h_sub_m = 10'(h_m << (h_lz + 4'd1));
    h_sub_e = H_BIAS_DIFF - {4'd0, h_lz};
    if (h_e == 5'd0) begin
      if (h_m == 10'd0) begin
        h2f = {h_s, 31'd0};
      end else begin
        h2f = {h_s, h_sub_e, h_sub_m, 13'd0};
      end
    end else if (h_e == H_EXP_MAX) begin
      h2f = {h_s, F32_EXP_MAX, h_m, 13'd0};
    end else begin
      h2f = {h_s, 8'({3'd0, h_e} + H_BIAS_DIFF), h_m, 13'd0};
    end
  end

  always_comb begin
    f_s      = s1_value_r[31];
    f_e      = s1_value_r[30:23];
    f_m      = s1_value_r[22:0];
    f_sh     = 4'(F2H_SUB_TOP - f_e);
    f_sub_sh = {1'b1, f_m} >> f_sh;
    f_sub    = {1'b0, f_sub_sh[22:13]} + {10'd0, f_sub_sh[12]};
    f_ex     = 5'(f_e - H_BIAS_DIFF);
    f_norm   = {f_ex, f_m[22:13]} + {14'd0, f_m[12]};
    if (f_e < F2H_UF_EXP) begin
      f2h = {f_s, 15'd0};
    end else if (f_e <= H_BIAS_DIFF) begin
      f2h = {f_s, 4'd0, f_sub};
    end else if (f_e >= F2H_OF_EXP) begin
      if (f_e == F32_EXP_MAX && f_m != 23'd0) begin
        f2h = {f_s, H_EXP_MAX, f_m[22:13] | H_QNAN_BIT};
      end else begin
        f2h = {f_s, H_EXP_MAX, 10'd0};
      end
    end else begin
      f2h = {f_s, f_norm};
    end
  end

  always_comb begin
    b_sum = s1_value_r + BF_RND_BIAS + {31'd0, s1_value_r[16]};
    if (s1_value_r[30:23] == F32_EXP_MAX && s1_value_r[22:0] != 23'd0) begin
      f2b = s1_value_r[31:16] | {9'd0, BF_QNAN_BIT};
    end else begin
      f2b = b_sum[31:16];
    end
  end

  always_comb begin
    case (s1_act_r)
      ACT_H2F: res_nxt = h2f;
      ACT_F2H: res_nxt = {16'd0, f2h};
      ACT_B2F: res_nxt = {s1_value_r[15:0], 16'd0};
      ACT_F2B: res_nxt = {16'd0, f2b};
      default: res_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_act_r   <= act_t'(in_action);
      s1_value_r <= in_value;
    end
    if (s1_valid_r && s2_ready) begin
      out_result_r <= res_nxt;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted word not held in input stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_value_r) && $stable(s1_act_r))
    else $error("input stage lost word under stall");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> out_valid_r && out_result == $past(res_nxt))
    else $error("result stage missed word");

  a_narrow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_act_r == ACT_F2H || s1_act_r == ACT_F2B) |-> res_nxt[31:16] == 16'd0)
    else $error("16-bit result not zero-extended");

endmodule
